FILE: src/kvip_pkg.sv
// shared types and constants for the key/value integer parser
// no dependencies; imported by every module of the block

package kvip_pkg;

   localparam int KIND_W       = 2;
   localparam int INDEX_W      = 6;
   localparam int CHAR_POS_W   = 5;
   localparam int BYTE_W       = 8;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 7;

   localparam logic [KIND_W-1:0] KIND_NAME_CHAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NAME_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd3;

   localparam logic PHASE_NAME  = 1'b0;
   localparam logic PHASE_VALUE = 1'b1;

   localparam logic [1:0] NUM_SKIP   = 2'd0;
   localparam logic [1:0] NUM_DIGITS = 2'd1;
   localparam logic [1:0] NUM_STOP   = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3d;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2c;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   localparam logic [COUNT_W-1:0] MAX_PAIRS_RESET = 7'd8;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [INDEX_W-1:0]        pair_index;
      logic [CHAR_POS_W-1:0]     char_pos;
      logic [BYTE_W-1:0]         name_char;
      logic signed [VALUE_W-1:0] pair_value;
      logic [COUNT_W-1:0]        pair_count;
   } kvip_result_type;

endpackage

FILE: src/kvip_in_stage.sv
// input register of the parser: holds one text byte until the parse stage takes it
// depends on kvip_pkg

module kvip_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [kvip_pkg::BYTE_W-1:0] req_text_byte,
   input  logic                      take,
   output logic                      held_valid,
   output logic [kvip_pkg::BYTE_W-1:0] held_byte
);
   import kvip_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_text_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

FILE: src/kvip_parse.sv
// parse state and per-byte decision logic: name tracking, atoi accumulation, pair count
// depends on kvip_pkg

module kvip_parse #(
   parameter int NAME_MAX = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [kvip_pkg::BYTE_W-1:0]  text_byte,
   input  logic [kvip_pkg::COUNT_W-1:0] max_pairs,
   output logic                        res_valid,
   output kvip_pkg::kvip_result_type   res
);
   import kvip_pkg::*;

   localparam int NAME_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam logic [NAME_W-1:0] POS_LAST = NAME_W'(NAME_MAX - 1);

   logic                      phase_ff, phase_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [NAME_W-1:0]         pos_ff, pos_in;
   logic [1:0]                num_ff, num_in;
   logic                      neg_ff, neg_in;
   logic [VALUE_W-1:0]        acc_ff, acc_in;

   logic [VALUE_W-1:0] digit;
   logic [VALUE_W-1:0] acc_times_ten;
   logic               is_digit;
   logic               is_blank;

   assign digit         = VALUE_W'(text_byte - CHAR_ZERO);
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign is_digit      = text_byte inside {[8'd48:8'd57]};
   assign is_blank      = text_byte inside {8'd32, [8'd9:8'd13]};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      res_valid = 1'b0;
      res       = '0;

      if (text_byte == CHAR_NUL) begin
         res_valid      = 1'b1;
         res.kind       = KIND_DONE;
         res.pair_count = count_ff;
         count_in       = '0;
         phase_in       = PHASE_NAME;
         pos_in         = '0;
         num_in         = NUM_SKIP;
         neg_in         = 1'b0;
         acc_in         = '0;
      end else if (count_ff >= max_pairs) begin
         res_valid = 1'b0;
      end else if (phase_ff == PHASE_NAME) begin
         res.pair_index = count_ff[INDEX_W-1:0];
         if (text_byte == CHAR_EQ) begin
            res_valid    = 1'b1;
            res.kind     = KIND_NAME_END;
            res.char_pos = CHAR_POS_W'(pos_ff);
            phase_in     = PHASE_VALUE;
            num_in       = NUM_SKIP;
            neg_in       = 1'b0;
            acc_in       = '0;
         end else if (pos_ff != POS_LAST) begin
            res_valid     = 1'b1;
            res.kind      = KIND_NAME_CHAR;
            res.char_pos  = CHAR_POS_W'(pos_ff);
            res.name_char = text_byte;
            pos_in        = pos_ff + 1'b1;
         end
      end else if (text_byte == CHAR_COMMA) begin
         res_valid      = 1'b1;
         res.kind       = KIND_VALUE;
         res.pair_index = count_ff[INDEX_W-1:0];
         res.pair_value = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
         count_in       = count_ff + 1'b1;
         phase_in       = PHASE_NAME;
         pos_in         = '0;
         num_in         = NUM_SKIP;
         neg_in         = 1'b0;
         acc_in         = '0;
      end else begin
         case (num_ff)
            NUM_SKIP: begin
               if (!is_blank) begin
                  if (text_byte == CHAR_PLUS || text_byte == CHAR_MINUS) begin
                     neg_in = (text_byte == CHAR_MINUS);
                     num_in = NUM_DIGITS;
                  end else if (is_digit) begin
                     acc_in = digit;
                     num_in = NUM_DIGITS;
                  end else begin
                     num_in = NUM_STOP;
                  end
               end
            end
            NUM_DIGITS: begin
               if (is_digit) begin
                  acc_in = acc_times_ten + digit;
               end else begin
                  num_in = NUM_STOP;
               end
            end
            default: begin
               num_in = num_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NAME;
         count_ff <= '0;
         pos_ff   <= '0;
         num_ff   <= NUM_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

FILE: src/key_value_integer_parser_top.sv
// top level of the key/value integer parser: config register, result register, wiring
// depends on kvip_pkg, kvip_in_stage and kvip_parse
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_text_byte
//   rsp_      out        rsp_valid / rsp_stall  rsp_kind .. rsp_pair_count
//   csr_      in         csr_wr_en              csr_wr_data (max_pairs)
//
// one byte per cycle sustained while rsp_ does not stall; a byte waits in the input
// register while the parse logic works on it, then its result (if any) sits in the
// result register.
// synchronous active-high reset clears control state and sets max_pairs to 8.
// a stall on rsp_ holds the result register and backs up into req_stall.

module key_value_integer_parser_top #(
   parameter int NAME_MAX = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [kvip_pkg::BYTE_W-1:0]  req_text_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kvip_pkg::KIND_W-1:0]     rsp_kind,
   output logic [kvip_pkg::INDEX_W-1:0]    rsp_pair_index,
   output logic [kvip_pkg::CHAR_POS_W-1:0] rsp_char_pos,
   output logic [kvip_pkg::BYTE_W-1:0]     rsp_name_char,
   output logic signed [kvip_pkg::VALUE_W-1:0] rsp_pair_value,
   output logic [kvip_pkg::COUNT_W-1:0]    rsp_pair_count,
   input  logic                        csr_wr_en,
   input  logic [kvip_pkg::COUNT_W-1:0] csr_wr_data
);
   import kvip_pkg::*;

   logic [COUNT_W-1:0] max_pairs_ff, max_pairs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kvip_result_type    rsp_ff, rsp_in;

   logic              held_valid;
   logic [BYTE_W-1:0] held_byte;
   logic              advance;
   logic              res_valid;
   kvip_result_type   res;

   assign advance = held_valid && (!rsp_valid_ff || !rsp_stall);

   kvip_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .take          (advance),
      .held_valid    (held_valid),
      .held_byte     (held_byte)
   );

   kvip_parse #(
      .NAME_MAX (NAME_MAX)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_byte (held_byte),
      .max_pairs (max_pairs_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      max_pairs_in = csr_wr_en ? csr_wr_data : max_pairs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff <= MAX_PAIRS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_pairs_ff <= max_pairs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_pair_index = rsp_ff.pair_index;
   assign rsp_char_pos   = rsp_ff.char_pos;
   assign rsp_name_char  = rsp_ff.name_char;
   assign rsp_pair_value = rsp_ff.pair_value;
   assign rsp_pair_count = rsp_ff.pair_count;

endmodule

FILE: test/key_value_integer_parser_top_tb.sv
// self-checking testbench for key_value_integer_parser_top: text strings in, parse results out
// depends on kvip_pkg and the parser RTL; carries its own predictor of the parse rules

module key_value_integer_parser_top_tb;
   import kvip_pkg::*;

   localparam int NAME_LIMIT    = 32;
   localparam int IDLE_PCT      = 36;
   localparam int SETTLE_CYCLES = 5;
   localparam int RUN_LIMIT     = 400000;

   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_HIGH  = 8'hff;

   typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} text_op_type;

   typedef struct {
      text_op_type       op;
      logic [BYTE_W-1:0] value;
   } text_entry_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [BYTE_W-1:0]           req_text_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [KIND_W-1:0]           rsp_kind;
   logic [INDEX_W-1:0]          rsp_pair_index;
   logic [CHAR_POS_W-1:0]       rsp_char_pos;
   logic [BYTE_W-1:0]           rsp_name_char;
   logic signed [VALUE_W-1:0]   rsp_pair_value;
   logic [COUNT_W-1:0]          rsp_pair_count;
   logic                        csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]          csr_wr_data = '0;

   text_entry_type    text_q[$];
   kvip_result_type   parse_result_q[$];

   logic              req_fire = 1'b0;
   int                settle_count = 0;
   int                bytes_sent = 0;
   int                bytes_taken = 0;
   int                queued_bytes = 0;
   int                results_seen = 0;
   int                cfg_writes = 0;
   int                error_count = 0;
   int                kind_seen[4] = '{0, 0, 0, 0};

   logic                 cur_in_value;
   logic [COUNT_W-1:0]   cur_pairs;
   logic [COUNT_W-1:0]   cur_max_pairs;
   logic [5:0]           cur_name_pos;
   logic [1:0]           cur_num_phase;
   logic                 cur_negative;
   logic [VALUE_W-1:0]   cur_acc;

   key_value_integer_parser_top #(
      .NAME_MAX(NAME_LIMIT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_pair_index (rsp_pair_index),
      .rsp_char_pos   (rsp_char_pos),
      .rsp_name_char  (rsp_name_char),
      .rsp_pair_value (rsp_pair_value),
      .rsp_pair_count (rsp_pair_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic bit is_digit(input logic [BYTE_W-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   task automatic begin_pair();
      cur_in_value  = PHASE_NAME;
      cur_name_pos  = '0;
      cur_num_phase = NUM_SKIP;
      cur_negative  = 1'b0;
      cur_acc       = '0;
   endtask

   task automatic parse_text_byte(input logic [BYTE_W-1:0] c, output bit produced,
                                  output kvip_result_type r);
      produced = 1'b0;
      r = '0;
      if (c == CHAR_NUL) begin
         produced = 1'b1;
         r.kind = KIND_DONE;
         r.pair_count = cur_pairs;
         cur_pairs = '0;
         begin_pair();
      end else if (cur_pairs >= cur_max_pairs) begin
         produced = 1'b0;
      end else if (cur_in_value == PHASE_NAME) begin
         if (c == CHAR_EQ) begin
            produced = 1'b1;
            r.kind = KIND_NAME_END;
            r.pair_index = cur_pairs[INDEX_W-1:0];
            r.char_pos = cur_name_pos[CHAR_POS_W-1:0];
            cur_in_value = PHASE_VALUE;
            cur_num_phase = NUM_SKIP;
            cur_negative = 1'b0;
            cur_acc = '0;
         end else if (cur_name_pos + 1 < NAME_LIMIT) begin
            produced = 1'b1;
            r.kind = KIND_NAME_CHAR;
            r.pair_index = cur_pairs[INDEX_W-1:0];
            r.char_pos = cur_name_pos[CHAR_POS_W-1:0];
            r.name_char = c;
            cur_name_pos = cur_name_pos + 1'b1;
         end
      end else if (c == CHAR_COMMA) begin
         produced = 1'b1;
         r.kind = KIND_VALUE;
         r.pair_index = cur_pairs[INDEX_W-1:0];
         r.pair_value = cur_negative ? -cur_acc : cur_acc;
         cur_pairs = cur_pairs + 1'b1;
         begin_pair();
      end else if (cur_num_phase == NUM_SKIP) begin
         if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            cur_num_phase = NUM_SKIP;
         end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            cur_negative = (c == CHAR_MINUS);
            cur_num_phase = NUM_DIGITS;
         end else if (is_digit(c)) begin
            cur_acc = 32'(c - CHAR_ZERO);
            cur_num_phase = NUM_DIGITS;
         end else begin
            cur_num_phase = NUM_STOP;
         end
      end else if (cur_num_phase == NUM_DIGITS) begin
         if (is_digit(c)) begin
            cur_acc = cur_acc * 32'd10 + 32'(c - CHAR_ZERO);
         end else begin
            cur_num_phase = NUM_STOP;
         end
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      bit produced;
      kvip_result_type predicted;
      kvip_result_type want;
      if (reset) begin
         cur_max_pairs = MAX_PAIRS_RESET;
         cur_pairs = '0;
         begin_pair();
         req_fire <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cur_max_pairs = csr_wr_data;
            cfg_writes++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (parse_result_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_kind);
               error_count++;
            end else begin
               want = parse_result_q.pop_front();
               kind_seen[want.kind]++;
               check_field("kind", want.kind, rsp_kind);
               check_field("pair_index", want.pair_index, rsp_pair_index);
               check_field("char_pos", want.char_pos, rsp_char_pos);
               check_field("name_char", want.name_char, rsp_name_char);
               check_field("pair_value", want.pair_value, rsp_pair_value);
               check_field("pair_count", want.pair_count, rsp_pair_count);
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            parse_text_byte(req_text_byte, produced, predicted);
            if (produced) parse_result_q.push_back(predicted);
         end
         req_fire <= req_valid && !req_stall;
      end
   end

   // text driver
   always @(negedge clock) begin
      logic              next_valid;
      logic [BYTE_W-1:0] next_byte;
      logic              next_wr;
      logic [COUNT_W-1:0] next_data;
      next_valid = req_valid && !req_fire;
      next_byte = req_text_byte;
      next_wr = 1'b0;
      next_data = csr_wr_data;
      if (!reset && !next_valid && text_q.size() != 0) begin
         if (text_q[0].op == OP_BYTE) begin
            settle_count = 0;
            if ((bytes_sent >= 150 && bytes_sent < 280) || $urandom_range(99) >= IDLE_PCT) begin
               next_valid = 1'b1;
               next_byte = text_q[0].value;
               void'(text_q.pop_front());
               bytes_sent++;
            end
         end else if (parse_result_q.size() != 0) begin
            settle_count = 0;
         end else if (settle_count < SETTLE_CYCLES) begin
            settle_count++;
         end else begin
            if (text_q[0].op == OP_CFG) begin
               next_wr = 1'b1;
               next_data = text_q[0].value[COUNT_W-1:0];
            end
            void'(text_q.pop_front());
            settle_count = 0;
         end
      end
      req_valid <= next_valid;
      req_text_byte <= next_byte;
      csr_wr_en <= next_wr;
      csr_wr_data <= next_data;
   end

   // result receiver
   always @(negedge clock) begin
      rsp_stall <= !(results_seen >= 100 && results_seen < 220)
                   && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      text_q.push_back('{OP_BYTE, b});
      queued_bytes++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic add_random_string();
      int n_pairs;
      int name_chars;
      int n_digits;
      logic [BYTE_W-1:0] b;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(12, 1)) push_byte(8'($urandom_range(255, 1)));
      end else begin
         n_pairs = ($urandom_range(7) == 0) ? $urandom_range(14, 7) : $urandom_range(6);
         for (int p = 0; p < n_pairs; p++) begin
            name_chars = ($urandom_range(15) == 0) ? $urandom_range(36, 30)
                                                   : $urandom_range(4);
            for (int i = 0; i < name_chars; i++) begin
               case ($urandom_range(9))
                  0: b = CHAR_COMMA;
                  1: b = 8'($urandom_range(255, 1));
                  default: b = 8'($urandom_range(8'h7a, 8'h61));
               endcase
               if (b == CHAR_EQ) b = CHAR_HIGH;
               push_byte(b);
            end
            push_byte(CHAR_EQ);
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(2, 1))
                  push_byte($urandom_range(1) ? CHAR_SPACE
                                              : 8'($urandom_range(CHAR_CR, CHAR_TAB)));
            end
            case ($urandom_range(3))
               0: push_byte(CHAR_PLUS);
               1: push_byte(CHAR_MINUS);
               default: ;
            endcase
            n_digits = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4);
            repeat (n_digits) push_byte(8'($urandom_range(CHAR_NINE, CHAR_ZERO)));
            if ($urandom_range(5) == 0) begin
               repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255, 1)));
            end
            if (p < n_pairs - 1 || $urandom_range(4) != 0) push_byte(CHAR_COMMA);
         end
      end
      push_byte(CHAR_NUL);
   endtask

   initial begin
      int phase_bytes[6];
      logic [COUNT_W-1:0] phase_limit[6];
      int goal;
      phase_bytes = '{70, 15, 45, 60, 80, 90};
      phase_limit = '{7'd64, 7'd0, 7'd1, 7'd2, 7'($urandom_range(64, 3)), 7'd8};

      // directed: sign, comma in name, whitespace, junk in value, empty pair, unclosed pair
      push_text("k=-42,");
      push_text(",x");
      push_byte(CHAR_HIGH);
      push_text("= ");
      push_byte(CHAR_TAB);
      push_text("+7z3,=,q=5");
      push_byte(CHAR_NUL);

      foreach (phase_limit[ph]) begin
         text_q.push_back('{OP_CFG, BYTE_W'(phase_limit[ph])});
         goal = queued_bytes + phase_bytes[ph];
         while (queued_bytes < goal) begin
            add_random_string();
            if (ph == 3 && queued_bytes >= goal - phase_bytes[ph] / 2
                && text_q[$].op == OP_BYTE && $urandom_range(3) == 0)
               text_q.push_back('{OP_DRAIN, '0});
         end
      end
      text_q.push_back('{OP_DRAIN, '0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_valid || parse_result_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d bytes and %0d results: %0d name chars, %0d name ends,",
               bytes_taken, results_seen, kind_seen[KIND_NAME_CHAR], kind_seen[KIND_NAME_END]);
      $display("%0d pair values and %0d finished strings over %0d max_pairs settings",
               kind_seen[KIND_VALUE], kind_seen[KIND_DONE], cfg_writes);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("timeout with %0d transactions still expected", parse_result_q.size());
      $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
src/kvip_pkg.sv
src/kvip_in_stage.sv
src/kvip_parse.sv
src/key_value_integer_parser_top.sv
test/key_value_integer_parser_top_tb.sv
